### rtl/rgbcg_pkg.sv
`default_nettype none
package rgbcg_pkg;

  localparam int unsigned CFG_W      = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PIXEL_W    = 16;
  localparam int unsigned GRAY_W     = 8;
  localparam int unsigned LUMA_SUM_W = 16;

  localparam int unsigned MAX_FRAME_DIM_DEF = 1024;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = CFG_W'(160);
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = CFG_W'(120);
  localparam logic [CFG_W-1:0] RST_CROP_LEFT    = CFG_W'(32);
  localparam logic [CFG_W-1:0] RST_CROP_TOP     = CFG_W'(12);
  localparam logic [CFG_W-1:0] RST_CROP_WIDTH   = CFG_W'(96);
  localparam logic [CFG_W-1:0] RST_CROP_HEIGHT  = CFG_W'(96);

  // bt.601 integer luma weights, sum is 256
  localparam logic [LUMA_SUM_W-1:0] LUMA_R = LUMA_SUM_W'(77);
  localparam logic [LUMA_SUM_W-1:0] LUMA_G = LUMA_SUM_W'(150);
  localparam logic [LUMA_SUM_W-1:0] LUMA_B = LUMA_SUM_W'(29);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_CROP_LEFT    = 3'd2,
    REG_CROP_TOP     = 3'd3,
    REG_CROP_WIDTH   = 3'd4,
    REG_CROP_HEIGHT  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [CFG_W-1:0] frame_width;
    logic [CFG_W-1:0] frame_height;
    logic [CFG_W-1:0] crop_left;
    logic [CFG_W-1:0] crop_top;
    logic [CFG_W-1:0] crop_width;
    logic [CFG_W-1:0] crop_height;
  } cfg_t;

  typedef struct packed {
    logic               keep;
    logic               row_end;
    logic               frame_end;
    logic [PIXEL_W-1:0] pixel;
  } pix_t;

endpackage
`default_nettype wire

### rtl/rgbcg_cfg.sv
`default_nettype none
module rgbcg_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rgbcg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [rgbcg_pkg::CFG_W-1:0]     cfg_wdata_i,
  output rgbcg_pkg::cfg_t                     cfg_o
);
  import rgbcg_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  cfg_d.frame_width  = cfg_wdata_i;
        REG_FRAME_HEIGHT: cfg_d.frame_height = cfg_wdata_i;
        REG_CROP_LEFT:    cfg_d.crop_left    = cfg_wdata_i;
        REG_CROP_TOP:     cfg_d.crop_top     = cfg_wdata_i;
        REG_CROP_WIDTH:   cfg_d.crop_width   = cfg_wdata_i;
        REG_CROP_HEIGHT:  cfg_d.crop_height  = cfg_wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= RST_FRAME_WIDTH;
      cfg_q.frame_height <= RST_FRAME_HEIGHT;
      cfg_q.crop_left    <= RST_CROP_LEFT;
      cfg_q.crop_top     <= RST_CROP_TOP;
      cfg_q.crop_width   <= RST_CROP_WIDTH;
      cfg_q.crop_height  <= RST_CROP_HEIGHT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

### rtl/rgbcg_track.sv
`default_nettype none
module rgbcg_track #(
  parameter int unsigned MAX_FRAME_DIM = rgbcg_pkg::MAX_FRAME_DIM_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         accept_i,
  input  wire logic [rgbcg_pkg::BYTE_W-1:0] data_byte_i,
  input  wire logic                         frame_start_i,
  input  wire rgbcg_pkg::cfg_t              cfg_i,
  output rgbcg_pkg::pix_t                   pix_o
);
  import rgbcg_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_DIM);
  localparam int unsigned CMP_W = (CNT_W + 1 > CFG_W + 1) ? CNT_W + 1 : CFG_W + 1;
  localparam logic [CMP_W-1:0] DIM_MAX = CMP_W'(MAX_FRAME_DIM);
  localparam logic [CMP_W-1:0] ONE     = CMP_W'(1);

  logic              phase_q, phase_d;
  logic [BYTE_W-1:0] hold_q, hold_d;
  logic [CNT_W-1:0]  col_q, col_d;
  logic [CNT_W-1:0]  row_q, row_d;

  logic             phase_eff;
  logic [CMP_W-1:0] fw, fh, fw_raw, fh_raw;
  logic [CMP_W-1:0] col_x, row_x, col_nx, row_nx;
  logic [CMP_W-1:0] col_sum, row_sum, col_stop, row_stop;
  logic             in_window;

  always_comb begin
    fw_raw = CMP_W'(cfg_i.frame_width);
    fh_raw = CMP_W'(cfg_i.frame_height);
    // zero size acts as one, oversize clamps to the counter range
    fw = (fw_raw == '0) ? ONE : ((fw_raw > DIM_MAX) ? DIM_MAX : fw_raw);
    fh = (fh_raw == '0) ? ONE : ((fh_raw > DIM_MAX) ? DIM_MAX : fh_raw);

    col_sum  = CMP_W'(cfg_i.crop_left) + CMP_W'(cfg_i.crop_width);
    row_sum  = CMP_W'(cfg_i.crop_top) + CMP_W'(cfg_i.crop_height);
    col_stop = (col_sum < fw) ? col_sum : fw;
    row_stop = (row_sum < fh) ? row_sum : fh;

    col_x  = CMP_W'(col_q);
    row_x  = CMP_W'(row_q);
    col_nx = col_x + ONE;
    row_nx = row_x + ONE;

    in_window = (col_x >= CMP_W'(cfg_i.crop_left)) && (col_x < col_stop) &&
                (row_x >= CMP_W'(cfg_i.crop_top)) && (row_x < row_stop);

    // frame start forces this byte to be a high byte
    phase_eff = phase_q && !frame_start_i;

    phase_d = phase_q;
    hold_d  = hold_q;
    col_d   = col_q;
    row_d   = row_q;
    if (accept_i) begin
      if (!phase_eff) begin
        phase_d = 1'b1;
        hold_d  = data_byte_i;
        if (frame_start_i) begin
          col_d = '0;
          row_d = '0;
        end
      end else begin
        phase_d = 1'b0;
        if (col_nx >= fw) begin
          col_d = '0;
          row_d = (row_nx >= fh) ? '0 : CNT_W'(row_nx);
        end else begin
          col_d = CNT_W'(col_nx);
        end
      end
    end

    pix_o.keep      = accept_i && phase_eff && in_window;
    pix_o.row_end   = (col_nx == col_stop);
    pix_o.frame_end = (col_nx == col_stop) && (row_nx == row_stop);
    pix_o.pixel     = {hold_q, data_byte_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      hold_q  <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      phase_q <= phase_d;
      hold_q  <= hold_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

endmodule
`default_nettype wire

### rtl/rgbcg_luma.sv
`default_nettype none
module rgbcg_luma (
  input  wire logic [rgbcg_pkg::PIXEL_W-1:0] pixel_i,
  output logic      [rgbcg_pkg::GRAY_W-1:0]  gray_o
);
  import rgbcg_pkg::*;

  logic [7:0]            r8, g8, b8;
  logic [LUMA_SUM_W-1:0] sum;

  always_comb begin
    r8  = {pixel_i[15:11], 3'b000};
    g8  = {pixel_i[10:5], 2'b00};
    b8  = {pixel_i[4:0], 3'b000};
    // max sum is 64088, fits 16 bits
    sum = LUMA_R * LUMA_SUM_W'(r8) + LUMA_G * LUMA_SUM_W'(g8) + LUMA_B * LUMA_SUM_W'(b8);
    gray_o = sum[LUMA_SUM_W-1 -: GRAY_W];
  end

endmodule
`default_nettype wire

### rtl/rgb565_crop_to_grayscale_core.sv
`default_nettype none
// Byte stream of big-endian RGB565 pixels in, 8-bit BT.601 luma out for pixels
// inside the crop window, with row_end and frame_end flags. One byte is taken
// every clock unless stalled; the luma of a pixel sits in the output register
// in the cycle after its low byte is accepted. The only stall is a full output
// register that the sink does not take; the byte pairing and the column/row
// counters advance in the same cycle a byte is accepted. frame_start clears the
// counters and makes its byte a high byte. Configuration writes are registered.
module rgb565_crop_to_grayscale_core #(
  parameter int unsigned MAX_FRAME_DIM = rgbcg_pkg::MAX_FRAME_DIM_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [rgbcg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [rgbcg_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [rgbcg_pkg::BYTE_W-1:0]    data_byte_i,
  input  wire logic                            frame_start_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [rgbcg_pkg::GRAY_W-1:0]    gray_o,
  output logic                                 row_end_o,
  output logic                                 frame_end_o
);
  import rgbcg_pkg::*;

  cfg_t              cfg;
  pix_t              pix;
  logic              accept;
  logic [GRAY_W-1:0] gray;

  logic              out_valid_q, out_valid_d;
  logic [GRAY_W-1:0] gray_q;
  logic              row_end_q, frame_end_q;

  rgbcg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rgbcg_track #(
    .MAX_FRAME_DIM (MAX_FRAME_DIM)
  ) u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .cfg_i         (cfg),
    .pix_o         (pix)
  );

  rgbcg_luma u_luma (
    .pixel_i (pix.pixel),
    .gray_o  (gray)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = pix.keep;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload loads only with a new item
  always_ff @(posedge clk_i) begin
    if (pix.keep) begin
      gray_q      <= gray;
      row_end_q   <= pix.row_end;
      frame_end_q <= pix.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign gray_o      = gray_q;
  assign row_end_o   = row_end_q;
  assign frame_end_o = frame_end_q;

endmodule
`default_nettype wire

### rtl/rgbcg_checker.sv
`default_nettype none
module rgbcg_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic frame_start_i,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic row_end_o,
  input wire logic frame_end_o
);

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while output item held");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("output item dropped before accept");

  // a frame start byte is always a high byte and gives no item
  a_frame_start_no_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && frame_start_i) |=> !out_valid_o)
    else $error("item produced from a frame start byte");

  a_frame_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> row_end_o)
    else $error("frame end without row end");

endmodule

bind rgb565_crop_to_grayscale_core rgbcg_checker u_rgbcg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .frame_start_i (frame_start_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .row_end_o     (row_end_o),
  .frame_end_o   (frame_end_o)
);
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps

typedef struct packed {
  logic [7:0] gray;
  logic       row_end;
  logic       frame_end;
} gray_pix_t;

class luma_scoreboard;
  rgbcg_pkg::cfg_t cfg;
  bit              low_next;
  logic [7:0]      held_hi;
  int unsigned     col;
  int unsigned     row;
  gray_pix_t       expected_pix[$];
  int              errors;

  function new();
    cfg.frame_width  = rgbcg_pkg::RST_FRAME_WIDTH;
    cfg.frame_height = rgbcg_pkg::RST_FRAME_HEIGHT;
    cfg.crop_left    = rgbcg_pkg::RST_CROP_LEFT;
    cfg.crop_top     = rgbcg_pkg::RST_CROP_TOP;
    cfg.crop_width   = rgbcg_pkg::RST_CROP_WIDTH;
    cfg.crop_height  = rgbcg_pkg::RST_CROP_HEIGHT;
    low_next = 1'b0;
    held_hi  = '0;
    col      = 0;
    row      = 0;
    errors   = 0;
  endfunction

  function int unsigned frame_span(logic [9:0] v);
    if (v == 0) return 1;
    if (v > rgbcg_pkg::MAX_FRAME_DIM_DEF) return rgbcg_pkg::MAX_FRAME_DIM_DEF;
    return v;
  endfunction

  function void apply_reg(logic [2:0] idx, logic [9:0] v);
    case (idx)
      rgbcg_pkg::REG_FRAME_WIDTH:  cfg.frame_width  = v;
      rgbcg_pkg::REG_FRAME_HEIGHT: cfg.frame_height = v;
      rgbcg_pkg::REG_CROP_LEFT:    cfg.crop_left    = v;
      rgbcg_pkg::REG_CROP_TOP:     cfg.crop_top     = v;
      rgbcg_pkg::REG_CROP_WIDTH:   cfg.crop_width   = v;
      rgbcg_pkg::REG_CROP_HEIGHT:  cfg.crop_height  = v;
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return expected_pix.size();
  endfunction

  // pairs bytes into pixels and predicts the luma item of a kept pixel
  function void note_byte(logic [7:0] b, logic fs);
    int unsigned fw, fh, col_stop, row_stop, r, g, bl, sum;
    logic [15:0] px;
    gray_pix_t   e;
    fw = frame_span(cfg.frame_width);
    fh = frame_span(cfg.frame_height);
    if (fs) begin
      col      = 0;
      row      = 0;
      low_next = 1'b0;
    end
    if (!low_next) begin
      held_hi  = b;
      low_next = 1'b1;
      return;
    end
    low_next = 1'b0;
    col_stop = cfg.crop_left;
    col_stop = col_stop + cfg.crop_width;
    if (col_stop > fw) col_stop = fw;
    row_stop = cfg.crop_top;
    row_stop = row_stop + cfg.crop_height;
    if (row_stop > fh) row_stop = fh;
    if (col >= cfg.crop_left && col < col_stop && row >= cfg.crop_top && row < row_stop) begin
      px  = {held_hi, b};
      r   = {px[15:11], 3'b000};
      g   = {px[10:5], 2'b00};
      bl  = {px[4:0], 3'b000};
      sum = 77 * r + 150 * g + 29 * bl;
      e.gray      = 8'(sum >> 8);
      e.row_end   = (col + 1 == col_stop);
      e.frame_end = (col + 1 == col_stop) && (row + 1 == row_stop);
      expected_pix.push_back(e);
    end
    if (col + 1 >= fw) begin
      col = 0;
      row = (row + 1 >= fh) ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
  endfunction

  function void check_result(logic [7:0] gray, logic row_end, logic frame_end);
    gray_pix_t e;
    if (expected_pix.size() == 0) begin
      errors++;
      $display("%0t: unexpected item, expected none, actual gray %0d row_end %b frame_end %b",
               $time, gray, row_end, frame_end);
      return;
    end
    e = expected_pix.pop_front();
    if (e.gray !== gray) begin
      errors++;
      $display("%0t: gray expected %0d actual %0d", $time, e.gray, gray);
    end
    if (e.row_end !== row_end) begin
      errors++;
      $display("%0t: row_end expected %b actual %b", $time, e.row_end, row_end);
    end
    if (e.frame_end !== frame_end) begin
      errors++;
      $display("%0t: frame_end expected %b actual %b", $time, e.frame_end, frame_end);
    end
  endfunction
endclass

module tb_top;
  import rgbcg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IDX_SPARE_HI = 3'd7;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [CFG_W-1:0]     cfg_wdata   = '0;
  logic                 in_valid    = 1'b0;
  logic [BYTE_W-1:0]    data_byte   = '0;
  logic                 frame_start = 1'b0;
  logic                 out_ready   = 1'b0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [GRAY_W-1:0]    gray_o;
  logic                 row_end_o;
  logic                 frame_end_o;

  luma_scoreboard sb = new();

  bit steady    = 1'b0;
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always #5 clk_i = ~clk_i;

  rgb565_crop_to_grayscale_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte),
    .frame_start_i(frame_start),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .gray_o       (gray_o),
    .row_end_o    (row_end_o),
    .frame_end_o  (frame_end_o)
  );

  // sink side: random stalls (none in steady mode), plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 9);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      sb.check_result(gray_o, row_end_o, frame_end_o);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk_i);
    sb.apply_reg(idx, v);
  endtask

  task automatic write_config(input logic [CFG_W-1:0] fw, input logic [CFG_W-1:0] fh,
                              input logic [CFG_W-1:0] cl, input logic [CFG_W-1:0] ct,
                              input logic [CFG_W-1:0] cw, input logic [CFG_W-1:0] ch);
    put_reg(REG_FRAME_WIDTH, fw);
    put_reg(REG_FRAME_HEIGHT, fh);
    put_reg(REG_CROP_LEFT, cl);
    put_reg(REG_CROP_TOP, ct);
    put_reg(REG_CROP_WIDTH, cw);
    put_reg(REG_CROP_HEIGHT, ch);
    // writes to unused indexes must not disturb anything
    put_reg($urandom_range(0, 1) ? REG_IDX_SPARE_HI : REG_IDX_SPARE_LO,
            CFG_W'($urandom_range(0, 1023)));
    cfg_we <= 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic fs);
    in_valid    <= 1'b1;
    data_byte   <= b;
    frame_start <= fs;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b, fs);
  endtask

  // wait for every predicted item, then let a pixel still in flight finish
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input int n_items, input int noise_pm, input int hold_at,
                           input int pause_at);
    int unsigned frame_bytes;
    int unsigned pos;
    logic [7:0]  b;
    logic        fs;
    frame_bytes = 2 * sb.frame_span(sb.cfg.frame_width) * sb.frame_span(sb.cfg.frame_height);
    pos = 0;
    for (int i = 0; i < n_items; i++) begin
      if (i == hold_at) hold_req++;
      if (i == pause_at) begin
        in_valid <= 1'b0;
        settle();
      end else if (i > 0 && !steady && $urandom_range(0, 99) < 9) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
      // mostly whole frames; now and then a frame start lands mid-frame
      if (pos == 0) fs = ($urandom_range(0, 19) != 0);
      else fs = ($urandom_range(0, 999) < noise_pm);
      if (fs) pos = 0;
      pos = (pos + 1) % frame_bytes;
      if ($urandom_range(0, 99) < 15) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else b = 8'($urandom_range(0, 255));
      push_byte(b, fs);
    end
    in_valid <= 1'b0;
    settle();
  endtask

  initial begin : main
    logic [15:0] pixels [9];
    pixels = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F,
               16'h8410, 16'h7BEF, 16'h0821, 16'hFFFF};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: the first row lies above the window
    run_phase(30, 5, -1, -1);

    // 3x3 frame with a window reaching past it on both sides
    write_config(10'd3, 10'd3, 10'd0, 10'd0, 10'd5, 10'd5);
    for (int k = 0; k < 9; k++) begin
      push_byte(pixels[k][15:8], k == 0);
      push_byte(pixels[k][7:0], 1'b0);
    end
    // held high byte is dropped by a second frame start
    push_byte(8'hC3, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'h1F, 1'b0);
    in_valid <= 1'b0;
    settle();

    write_config(10'd8, 10'd6, 10'd2, 10'd1, 10'd4, 10'd3);
    run_phase(200, 5, 50, 120);
    write_config(10'd0, 10'd0, 10'd0, 10'd0, 10'd1, 10'd1);
    run_phase(60, 5, -1, -1);
    write_config(10'd5, 10'd4, 10'd3, 10'd2, 10'd1023, 10'd1023);
    run_phase(150, 5, -1, -1);
    write_config(10'd6, 10'd5, 10'd2, 10'd2, 10'd0, 10'd3);
    run_phase(60, 5, -1, -1);
    write_config(10'd3, 10'd3, 10'd1023, 10'd1023, 10'd5, 10'd5);
    run_phase(40, 5, -1, -1);

    steady = 1'b1;
    write_config(10'd7, 10'd5, 10'd0, 10'd0, 10'd7, 10'd5);
    run_phase(140, 5, 100, -1);
    steady = 1'b0;

    write_config(10'd4, 10'd4, 10'd1, 10'd0, 10'd2, 10'd0);
    run_phase(40, 5, -1, -1);
    // widest and tallest frames, window reaching past the frame
    write_config(10'd1023, 10'd1, 10'd0, 10'd0, 10'd13, 10'd1023);
    run_phase(60, 0, -1, -1);
    write_config(10'd1, 10'd1023, 10'd0, 10'd2, 10'd1023, 10'd8);
    run_phase(60, 0, -1, -1);
    write_config(10'd2, 10'd2, 10'd0, 10'd0, 10'd1, 10'd2);
    run_phase(90, 5, -1, -1);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
